[rtl/heat_grid_stencil_sweeper_unit_assert.svh]
// assertion macros for the heat grid stencil sweeper
`ifndef HEAT_GRID_STENCIL_SWEEPER_UNIT_ASSERT_SVH
`define HEAT_GRID_STENCIL_SWEEPER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define HGS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define HGS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define HGS_ASSERT_SAME(label, ante, cons)
`define HGS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/hgs_pkg.sv]
// package: widths, codes, reset values and state type of the stencil sweeper
package hgs_pkg;
	localparam int GRID_MAX_DEF = 64;
	localparam int FUNC_W = 2;
	localparam int ROWCOL_W = 6;
	localparam int VAL_W = 16;
	localparam int GSIZE_W = 7;
	localparam int SWEEP_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_RUN = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_COUNT = 2'd1;

	localparam logic [GSIZE_W-1:0] GRID_SIZE_RST = 7'd64;
	localparam logic [SWEEP_W-1:0] SWEEP_COUNT_RST = 16'd5000;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_ROW0,
		S_ROW1,
		S_UP,
		S_DN,
		S_RT,
		S_WB
	} state_t;
endpackage

[rtl/hgs_if.sv]
// item channel interfaces of the stencil sweeper
interface hgs_in_if import hgs_pkg::*; ();
	logic valid;
	logic ready;
	logic [FUNC_W-1:0] func;
	logic [ROWCOL_W-1:0] row;
	logic [ROWCOL_W-1:0] col;
	logic [VAL_W-1:0] value;

	modport source(output valid, func, row, col, value, input ready);
	modport sink(input valid, func, row, col, value, output ready);
endinterface

interface hgs_out_if import hgs_pkg::*; ();
	logic valid;
	logic ready;
	logic [VAL_W-1:0] read_value;
	logic status;

	modport source(output valid, read_value, status, input ready);
	modport sink(input valid, read_value, status, output ready);
endinterface

[rtl/heat_grid_stencil_sweeper_unit.sv]
// top level: grid memory with write, read and gauss-seidel relaxation runs
//
// channel   dir  handshake      payload
// in_ch     in   valid/ready    func, row, col, value
// out_ch    out  valid/ready    read_value, status
// cfg       in   cfg_we         cfg_idx, cfg_wdata
//
// writes and out-of-range items answer from S_IDLE, reads from S_RD after the memory read
// a run: S_ROW0, S_ROW1 per row, S_UP, S_DN, S_RT, S_WB per cell, (n-2) rows per sweep;
// each cell does three memory reads and one write through the single read port
// the run stops early after a sweep that changes no cell
// reset clears control and config state; data registers and grid memory are undefined
// in_ch is taken only in S_IDLE with no run answer pending and the output slot free
`include "heat_grid_stencil_sweeper_unit_assert.svh"
module heat_grid_stencil_sweeper_unit import hgs_pkg::*; #(
	parameter int GRID_MAX = GRID_MAX_DEF
) (
	input logic clk,
	input logic arst_n,
	hgs_in_if.sink in_ch,
	hgs_out_if.source out_ch,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [CFG_DATA_W-1:0] cfg_wdata
);
	localparam int IW = $clog2(GRID_MAX);
	localparam int NW = $clog2(GRID_MAX + 1);
	localparam int CW = NW + 1;
	localparam int AW = 2 * IW;
	localparam int DEPTH = 1 << AW;

	function automatic logic [AW-1:0] cell_addr(logic [IW-1:0] r, logic [IW-1:0] c);
		return {r, c};
	endfunction

	state_t state_q, state_d;
	logic done_q;
	logic [GSIZE_W-1:0] grid_size_q;
	logic [SWEEP_W-1:0] sweep_q;
	logic [IW-1:0] r_q, c_q;
	logic [SWEEP_W-1:0] k_q;
	logic chg_q;
	logic [VAL_W-1:0] left_q, center_q, up_q, dn_q;
	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rdata_q;
	logic out_valid_q;
	logic [VAL_W-1:0] rd_val_q;
	logic status_q;

	logic [NW-1:0] n;
	logic slot_free, oor, last_col, last_row, sweep_fin, cell_chg;
	logic mem_we, mem_re;
	logic [AW-1:0] waddr, raddr, addr_in;
	logic [VAL_W-1:0] wdata, new_val;
	logic [VAL_W+1:0] sum;
	logic out_load, out_st, run_start, done_d;
	logic [VAL_W-1:0] out_rd;

	always_comb begin
		if (32'(grid_size_q) > GRID_MAX) begin
			n = NW'(GRID_MAX);
		end else begin
			n = NW'(grid_size_q);
		end
	end

	assign slot_free = !out_valid_q || out_ch.ready;
	assign oor = (32'(in_ch.row) >= 32'(n)) || (32'(in_ch.col) >= 32'(n));
	assign addr_in = cell_addr(IW'(in_ch.row), IW'(in_ch.col));
	assign sum = (VAL_W + 2)'(up_q) + (VAL_W + 2)'(dn_q) + (VAL_W + 2)'(left_q)
		+ (VAL_W + 2)'(rdata_q);
	assign new_val = sum[VAL_W+1:2];
	assign cell_chg = new_val != center_q;
	assign last_col = (CW'(c_q) + CW'(2)) >= CW'(n);
	assign last_row = (CW'(r_q) + CW'(2)) >= CW'(n);
	assign sweep_fin = !(chg_q || cell_chg) || ((k_q + SWEEP_W'(1)) == sweep_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= done_d;
		end
	end

	always_comb begin
		state_d = state_q;
		done_d = done_q;
		in_ch.ready = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		waddr = addr_in;
		raddr = addr_in;
		wdata = in_ch.value;
		out_load = 1'b0;
		out_rd = '0;
		out_st = 1'b0;
		run_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (done_q) begin
					if (slot_free) begin
						out_load = 1'b1;
						done_d = 1'b0;
					end
				end else begin
					in_ch.ready = slot_free;
					if (in_ch.valid && slot_free) begin
						case (in_ch.func)
							FUNC_WRITE: begin
								out_load = 1'b1;
								out_st = oor;
								mem_we = !oor;
							end
							FUNC_READ: begin
								if (oor) begin
									out_load = 1'b1;
									out_st = 1'b1;
								end else begin
									mem_re = 1'b1;
									state_d = S_RD;
								end
							end
							FUNC_RUN: begin
								run_start = 1'b1;
								if (sweep_q == '0 || 32'(n) < 3) begin
									done_d = 1'b1;
								end else begin
									state_d = S_ROW0;
								end
							end
							default: begin
								out_load = 1'b1;
							end
						endcase
					end
				end
			end
			S_RD: begin
				if (slot_free) begin
					out_load = 1'b1;
					out_rd = rdata_q;
					state_d = S_IDLE;
				end
			end
			S_ROW0: begin
				mem_re = 1'b1;
				raddr = cell_addr(r_q, '0);
				state_d = S_ROW1;
			end
			S_ROW1: begin
				mem_re = 1'b1;
				raddr = cell_addr(r_q, IW'(1));
				state_d = S_UP;
			end
			S_UP: begin
				mem_re = 1'b1;
				raddr = cell_addr(r_q - IW'(1), c_q);
				state_d = S_DN;
			end
			S_DN: begin
				mem_re = 1'b1;
				raddr = cell_addr(r_q + IW'(1), c_q);
				state_d = S_RT;
			end
			S_RT: begin
				mem_re = 1'b1;
				raddr = cell_addr(r_q, c_q + IW'(1));
				state_d = S_WB;
			end
			S_WB: begin
				mem_we = 1'b1;
				waddr = cell_addr(r_q, c_q);
				wdata = new_val;
				if (!last_col) begin
					state_d = S_UP;
				end else if (!last_row) begin
					state_d = S_ROW0;
				end else if (sweep_fin) begin
					state_d = S_IDLE;
					done_d = 1'b1;
				end else begin
					state_d = S_ROW0;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// sweep position, sweep count and change flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			c_q <= '0;
			k_q <= '0;
			chg_q <= 1'b0;
		end else if (run_start) begin
			r_q <= IW'(1);
			c_q <= IW'(1);
			k_q <= '0;
			chg_q <= 1'b0;
		end else if (state_q == S_WB) begin
			if (!last_col) begin
				c_q <= c_q + IW'(1);
				chg_q <= chg_q || cell_chg;
			end else if (!last_row) begin
				c_q <= IW'(1);
				r_q <= r_q + IW'(1);
				chg_q <= chg_q || cell_chg;
			end else begin
				c_q <= IW'(1);
				r_q <= IW'(1);
				k_q <= k_q + SWEEP_W'(1);
				chg_q <= 1'b0;
			end
		end
	end

	// stencil operands
	always_ff @(posedge clk) begin
		case (state_q)
			S_ROW1: left_q <= rdata_q;
			S_UP: center_q <= rdata_q;
			S_DN: up_q <= rdata_q;
			S_RT: dn_q <= rdata_q;
			S_WB: left_q <= new_val;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= GRID_SIZE_RST;
			sweep_q <= SWEEP_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_GRID_SIZE: grid_size_q <= cfg_wdata[GSIZE_W-1:0];
				CFG_SWEEP_COUNT: sweep_q <= cfg_wdata[SWEEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rd_val_q <= out_rd;
			status_q <= out_st;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.read_value = rd_val_q;
	assign out_ch.status = status_q;

	`HGS_ASSERT_SAME(a_wb_interior, state_q == S_WB, r_q != '0 && c_q != '0)
	`HGS_ASSERT_SAME(a_sweep_bound, state_q == S_ROW0 || state_q == S_WB, k_q < sweep_q)
	`HGS_ASSERT_NEXT(a_run_busy, run_start, state_q != S_IDLE || done_q)
endmodule
